// ----- rtl/core/linear_probe_hash_table_defines.svh -----
// Assertion helpers used by linear_probe_hash_table.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LPHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: next-cycle check failed");

`endif

// ----- rtl/core/lpht_pkg.sv -----
package lpht_pkg;

  localparam int TABLE_SIZE = 11;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int REM_W      = SLOT_W + 1;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int ENTRY_W    = KEY_W + VAL_W;
  localparam int STATUS_W   = 2;
  localparam int SLOT_FW    = 4;

  localparam int MOD_DIGIT  = 4;
  localparam int MOD_STEPS  = (KEY_W + MOD_DIGIT - 1) / MOD_DIGIT;
  localparam int MOD_PAD_W  = MOD_STEPS * MOD_DIGIT;
  localparam int MOD_CNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ----- rtl/core/lpht_ram.sv -----
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lpht_mod.sv -----
module lpht_mod
  import lpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [SLOT_W-1:0] rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_PAD_W-1:0] sh_r, sh_nxt;
  logic [SLOT_W-1:0]    rem_r, rem_nxt;

  logic [SLOT_W-1:0]    step_rem;
  logic [REM_W-1:0]     trial;
  logic [MOD_DIGIT-1:0] digit;

  always_comb begin
    digit    = sh_r[MOD_PAD_W-1 -: MOD_DIGIT];
    step_rem = rem_r;
    trial    = '0;
    for (int i = MOD_DIGIT - 1; i >= 0; i--) begin
      trial = {step_rem, digit[i]};
      if (trial >= REM_W'(TABLE_SIZE)) begin
        trial = trial - REM_W'(TABLE_SIZE);
      end
      step_rem = trial[SLOT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = MOD_PAD_W'(key);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = step_rem;
      sh_nxt  = sh_r << MOD_DIGIT;
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// channel | signals                                  | direction
// in      | in_valid in_ready in_req_type in_key     | beat in
//         | in_value                                 |
// out     | out_valid out_ready out_status out_slot  | beat out
//         | out_found_value                          |
//
// A request is taken only while the block is idle; one request at a time.
// Hash: key mod TABLE_SIZE, four key bits per cycle, then one done strobe.
// Insert: slots probed in turn in the occupancy flops, 1 to TABLE_SIZE of them.
// Search: probes read the key/value RAM in turn; compares use its registered data.
// One more cycle moves the result into the output register; hold there while
// it still holds an unaccepted beat. Reset clears occupancy at once.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_FW-1:0]  out_slot,
  output logic [VAL_W-1:0]    out_found_value
);

`include "linear_probe_hash_table_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                req_r, req_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic [SLOT_W-1:0]   n_r, n_nxt;
  logic [SLOT_W-1:0]   cmp_pos_r, cmp_pos_nxt;
  logic [SLOT_W-1:0]   cmp_n_r, cmp_n_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [TABLE_SIZE-1:0] occ_r, occ_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [VAL_W-1:0]    res_val_r, res_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_FW-1:0]  out_slot_r, out_slot_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;

  logic                mod_start;
  logic                mod_done;
  logic [SLOT_W-1:0]   mod_rem;
  logic                ram_we;
  logic [ENTRY_W-1:0]  rd_data;
  logic [KEY_W-1:0]    rd_key;
  logic [VAL_W-1:0]    rd_val;
  logic [SLOT_W-1:0]   pos_inc;
  logic                accept;
  logic                out_miss;
  logic                out_zero;

  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata ({key_r, val_r}),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  assign rd_key    = rd_data[ENTRY_W-1 -: KEY_W];
  assign rd_val    = rd_data[VAL_W-1:0];
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mod_start = accept;
  assign pos_inc   = (pos_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_r + SLOT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    cmp_pos_nxt    = cmp_pos_r;
    cmp_n_nxt      = cmp_n_r;
    cmp_vld_nxt    = cmp_vld_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_val_nxt    = out_val_r;
    ram_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req_type;
          key_nxt   = in_key;
          val_nxt   = in_value;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_nxt     = mod_rem;
          n_nxt       = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = req_r ? S_SRCH : S_INS;
        end
      end
      S_INS: begin
        if (!occ_r[pos_r]) begin
          ram_we         = 1'b1;
          occ_nxt[pos_r] = 1'b1;
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = pos_r;
          res_val_nxt    = '0;
          state_nxt      = S_OUT;
        end else if (n_r == SLOT_W'(TABLE_SIZE - 1)) begin
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
          res_val_nxt    = '0;
          state_nxt      = S_OUT;
        end else begin
          pos_nxt = pos_inc;
          n_nxt   = n_r + SLOT_W'(1);
        end
      end
      S_SRCH: begin
        cmp_pos_nxt = pos_r;
        cmp_n_nxt   = n_r;
        cmp_vld_nxt = 1'b1;
        pos_nxt     = pos_inc;
        if (n_r != SLOT_W'(TABLE_SIZE - 1)) begin
          n_nxt = n_r + SLOT_W'(1);
        end
        if (cmp_vld_r) begin
          if (!occ_r[cmp_pos_r]) begin
            res_status_nxt = ST_NOT_FOUND;
            res_slot_nxt   = '0;
            res_val_nxt    = '0;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_OUT;
          end else if (rd_key == key_r) begin
            res_status_nxt = ST_FOUND;
            res_slot_nxt   = cmp_pos_r;
            res_val_nxt    = rd_val;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_OUT;
          end else if (cmp_n_r == SLOT_W'(TABLE_SIZE - 1)) begin
            res_status_nxt = ST_NOT_FOUND;
            res_slot_nxt   = '0;
            res_val_nxt    = '0;
            cmp_vld_nxt    = 1'b0;
            state_nxt      = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_FW'(res_slot_r);
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    cmp_pos_r    <= cmp_pos_nxt;
    cmp_n_r      <= cmp_n_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_found_value = out_val_r;

  assign out_miss = out_valid_r && (out_status_r == ST_NOT_FOUND || out_status_r == ST_FULL);
  assign out_zero = (out_slot_r == '0) && (out_val_r == '0);

  `LPHT_ASSERT_IMP(a_miss_zero, out_miss, out_zero)
  `LPHT_ASSERT_NXT(a_write_marks, ram_we, occ_r[$past(pos_r)])
  `LPHT_ASSERT_IMP(a_home_range, mod_done, mod_rem < SLOT_W'(TABLE_SIZE))

endmodule

// ----- dv/lpht_checker.sv -----
package lpht_tb_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

endpackage

module lpht_checker
  import lpht_pkg::*;
  import lpht_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_req_type,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [SLOT_FW-1:0]  out_slot,
  input  logic [VAL_W-1:0]    out_found_value,
  output int                  mismatches,
  output int                  pending,
  output int                  n_compared,
  output int                  n_found,
  output int                  n_full
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_FW-1:0]  slot;
    logic [VAL_W-1:0]    found_value;
  } probe_result_t;

  logic                slot_used [TABLE_SIZE];
  logic [KEY_W-1:0]    slot_key  [TABLE_SIZE];
  logic [VAL_W-1:0]    slot_val  [TABLE_SIZE];
  probe_result_t       probe_results_q [$];

  function automatic probe_result_t probe_table(logic rt, logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v);
    probe_result_t r;
    int unsigned   pos;
    r = '0;
    pos = k % TABLE_SIZE;
    r.status = (rt == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (rt == REQ_INSERT) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos]  = k;
          slot_val[pos]  = v;
          r.status = ST_INSERTED;
          r.slot   = SLOT_FW'(pos);
          break;
        end
      end else begin
        if (!slot_used[pos])
          break;
        if (slot_key[pos] == k) begin
          r.status      = ST_FOUND;
          r.slot        = SLOT_FW'(pos);
          r.found_value = slot_val[pos];
          break;
        end
      end
      pos = (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    probe_result_t want;
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      probe_results_q.delete();
    end else begin
      if (in_valid && in_ready)
        probe_results_q.push_back(probe_table(in_req_type, in_key, in_value));
      if (out_valid && out_ready) begin
        if (probe_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat: status %0d slot %0d value %h", $realtime,
                     out_status, out_slot, out_found_value);
        end else begin
          want = probe_results_q.pop_front();
          if (out_status !== want.status || out_slot !== want.slot ||
              out_found_value !== want.found_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: beat %0d: expected status %0d slot %0d value %h, got status %0d slot %0d value %h",
                       $realtime, n_compared, want.status, want.slot, want.found_value,
                       out_status, out_slot, out_found_value);
          end
          n_compared++;
          if (want.status == ST_FOUND) n_found++;
          if (want.status == ST_FULL) n_full++;
        end
      end
    end
    pending = probe_results_q.size();
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;
  import lpht_tb_pkg::*;

  localparam int               RANDOM_ITEMS = 630;
  localparam int               IDLE_LIMIT   = 5000;
  localparam int               LONG_HOLD    = 300;
  localparam int               TAIL_CYCLES  = 40;
  localparam logic [KEY_W-1:0] KEY_MAX      = {KEY_W{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_req_type;
  logic [KEY_W-1:0]    in_key;
  logic [VAL_W-1:0]    in_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_FW-1:0]  out_slot;
  logic [VAL_W-1:0]    out_found_value;

  int mismatches;
  int pending;
  int n_compared;
  int n_found;
  int n_full;

  int               n_insert;
  int               n_search;
  int               burst_left;
  logic [KEY_W-1:0] used_keys [$];

  always #1 clk = ~clk;

  linear_probe_hash_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_found_value (out_found_value)
  );

  lpht_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_found_value (out_found_value),
    .mismatches      (mismatches),
    .pending         (pending),
    .n_compared      (n_compared),
    .n_found         (n_found),
    .n_full          (n_full)
  );

  function automatic logic [KEY_W-1:0] key_at_home(int unsigned h);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if (k > KEY_MAX - KEY_W'(TABLE_SIZE)) k = k - KEY_W'(TABLE_SIZE);
    return k - KEY_W'(k % TABLE_SIZE) + KEY_W'(h);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  task automatic push_req(input logic rt, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_key      <= k;
    in_value    <= v;
    do @(posedge clk); while (!in_ready);
    if (rt == REQ_INSERT) begin
      n_insert++;
      used_keys.push_back(k);
    end else begin
      n_search++;
    end
  endtask

  // receiver: changing stall patterns, one long hold-off to back up the input
  initial begin
    int mode;
    int mode_left;
    int out_beats;
    bit held;
    mode = 0;
    mode_left = 0;
    out_beats = 0;
    held = 1'b0;
    forever begin
      if (!held && out_beats >= 60) begin
        held = 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
      @(posedge clk);
      if (out_valid && out_ready) out_beats++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
    $display("linear_probe_hash_table test failed");
    $finish;
  end

  initial begin
    logic             rt;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int               sel;
    int               odds;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_INSERT;
    in_key      <= '0;
    in_value    <= '0;
    n_insert    = 0;
    n_search    = 0;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_req(REQ_SEARCH, KEY_W'(0), '1);
    push_req(REQ_INSERT, KEY_W'(0), '0);
    push_req(REQ_INSERT, KEY_MAX, '1);
    push_req(REQ_INSERT, KEY_W'(11), 32'h1234_5678);
    push_req(REQ_INSERT, KEY_W'(10), 32'h8000_0001);
    push_req(REQ_INSERT, KEY_W'(21), 32'hA5A5_5A5A);
    push_req(REQ_INSERT, KEY_W'(11), 32'hDEAD_BEEF);
    push_req(REQ_SEARCH, KEY_W'(11), '0);
    push_req(REQ_SEARCH, KEY_W'(21), $urandom);
    push_req(REQ_SEARCH, KEY_MAX, '0);
    push_req(REQ_SEARCH, KEY_W'(22), '1);
    push_req(REQ_SEARCH, KEY_W'(0), $urandom);
    push_req(REQ_SEARCH, KEY_MAX - KEY_W'(1), '0);
    push_req(REQ_SEARCH, KEY_W'(10), 32'h7FFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      odds = (i < 400) ? 60 : 4;
      rt = ($urandom_range(1, odds) == 1) ? REQ_INSERT : REQ_SEARCH;
      sel = $urandom_range(0, 9);
      if (rt == REQ_INSERT) begin
        if (sel <= 1 && used_keys.size() > 0)
          k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel <= 5)
          k = key_at_home(($urandom_range(0, 3) + 9) % TABLE_SIZE);
        else
          k = KEY_W'($urandom);
      end else begin
        if (sel <= 4 && used_keys.size() > 0)
          k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel <= 6 && used_keys.size() > 0)
          k = key_at_home(used_keys[$urandom_range(0, used_keys.size() - 1)] % TABLE_SIZE);
        else if (sel == 7)
          k = $urandom_range(0, 1) ? KEY_MAX : '0;
        else
          k = KEY_W'($urandom);
      end
      v = pick_value();
      push_req(rt, k, v);
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d inserts and %0d searches; %0d results checked", n_insert, n_search,
             n_compared);
    $display("%0d search hits, %0d inserts into a full table, one %0d-cycle hold-off",
             n_found, n_full, LONG_HOLD);
    if (mismatches == 0)
      $display("linear_probe_hash_table test passed");
    else
      $display("linear_probe_hash_table test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_mod.sv
rtl/core/linear_probe_hash_table.sv
dv/lpht_checker.sv
dv/tb.sv
